/* rtl/bbs_pkg.sv */
// Shared types and constants for the bounded bag store.
// No dependencies; imported by bbs_cell and bounded_bag_store.
`timescale 1ns / 1ps

package bbs_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int ENTRY_W = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]        CAP_RESET = CAP_W'(16);
    localparam logic signed [VAL_W-1:0] MISS_MARK = -32'sd24042003;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_CHECK  = 2'd1,
        OP_REMOVE = 2'd2
    } bbs_op_t;

    // Command broadcast to every cell in the row
    typedef struct packed
    {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } bbs_cmd_t;

endpackage

/* rtl/bounded_bag_store.sv */
// Bounded bag store: ordered multiset of signed 32-bit entries in a cell row.
// Depends on bbs_pkg and bbs_cell.
// The result word is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle while results are taken; the first-match
// chain across all DEPTH cells is combinational.
// Reset: count clears to zero and capacity returns to 16; entries are not
// cleared, only positions below count are ever read.
`timescale 1ns / 1ps

module bounded_bag_store
    import bbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CAP_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic signed [VAL_W-1:0]   item_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      success,
    output logic signed [VAL_W-1:0]   removed_value,
    output logic [ENTRY_W-1:0]        entry_count
);

    logic [CAP_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    success_reg;
    logic                    success_next;
    logic signed [VAL_W-1:0] removed_reg;
    logic signed [VAL_W-1:0] removed_next;
    logic [ENTRY_W-1:0]      entry_count_reg;

    logic                    accept;
    logic                    room;
    logic                    found;
    bbs_cmd_t                cmd;

    logic                    found_chain [DEPTH+1];
    logic signed [VAL_W-1:0] cell_value  [DEPTH];

    // Hold the input back only while a finished result is still waiting
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Insert needs space under both the programmed capacity and the row depth
    assign room = (CMP_W'(count_reg) < CMP_W'(capacity_reg))
               && (count_reg < CNT_W'(DEPTH));

    always_comb
    begin
        cmd.ins   = accept && (opcode == OP_INSERT) && room;
        cmd.rem   = accept && (opcode == OP_REMOVE);
        cmd.value = item_value;
        cmd.count = count_reg;
    end

    // Cell row: found ripples from the head, so only the first match and the
    // cells after it shift down on a remove.
    assign found_chain[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [VAL_W-1:0] right_value;

        if (k == DEPTH - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_body
            assign right_value = cell_value[k+1];
        end

        bbs_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .cell_idx    (IDX_W'(k)),
            .right_value (right_value),
            .found_in    (found_chain[k]),
            .found_out   (found_chain[k+1]),
            .value       (cell_value[k])
        );
    end

    assign found = found_chain[DEPTH];

    // Result decode and count update
    always_comb
    begin
        success_next = 1'b0;
        removed_next = '0;
        count_next   = count_reg;
        unique case (opcode)
            OP_INSERT:
            begin
                success_next = room;
                if (room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_CHECK:
            begin
                success_next = found;
            end
            OP_REMOVE:
            begin
                success_next = found;
                removed_next = found ? item_value : MISS_MARK;
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            success_reg     <= success_next;
            removed_reg     <= removed_next;
            entry_count_reg <= ENTRY_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign success       = success_reg;
    assign removed_value = removed_reg;
    assign entry_count   = entry_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds row depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("successful insert did not advance count");

    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count == ENTRY_W'(count_reg))
        else $error("reported count differs from stored count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

endmodule

/* rtl/bbs_cell.sv */
// One storage cell of the bag row: holds an entry, compares, shifts down.
// Depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_cell
    import bbs_pkg::*;
(
    input  logic                    clk,
    input  bbs_cmd_t                cmd,
    input  logic [IDX_W-1:0]        cell_idx,
    input  logic signed [VAL_W-1:0] right_value,
    input  logic                    found_in,
    output logic                    found_out,
    output logic signed [VAL_W-1:0] value
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    occupied;
    logic                    match;

    assign occupied  = CNT_W'(cell_idx) < cmd.count;
    assign match     = occupied && (value_reg == cmd.value);
    assign found_out = found_in | match;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins && (cmd.count == CNT_W'(cell_idx)))
        begin
            value_next = cmd.value;
        end
        else if (cmd.rem && found_out)
        begin
            // close the gap: take the neighbour's entry
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
